/* design/ldaqm_pkg.sv */
// Package for the load/delay AQM drop engine: payload structs, configuration
// struct, opcode and verdict codes, fixed-point constants and a rounding helper.
// No dependencies.
package ldaqm_pkg;

    localparam int LOAD_EXPONENT  = 3;
    localparam int IDLE_SLOT_BITS = 16;
    localparam int PEXP_W         = IDLE_SLOT_BITS + 1;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = 1;
    localparam int QCNT_W         = 2;
    localparam int DIV_STEPS      = 16;
    localparam int DCNT_W         = 4;
    localparam int ADDR_W         = 5;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] OP_ARRIVAL   = 2'd0;
    localparam logic [1:0] OP_TICK      = 2'd1;
    localparam logic [1:0] OP_DEQ_EMPTY = 2'd2;
    localparam logic [1:0] OP_DEQ_DONE  = 2'd3;

    localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [1:0] VERDICT_EARLY  = 2'd1;
    localparam logic [1:0] VERDICT_FORCED = 2'd2;

    localparam logic [2:0] REG_BYTE_MODE    = 3'd0;
    localparam logic [2:0] REG_QUEUE_LIMIT  = 3'd1;
    localparam logic [2:0] REG_QUEUE_WEIGHT = 3'd2;
    localparam logic [2:0] REG_RATE_WEIGHT  = 3'd3;
    localparam logic [2:0] REG_DELAY_WEIGHT = 3'd4;
    localparam logic [2:0] REG_QUEUE_TARGET = 3'd5;
    localparam logic [2:0] REG_LOAD_TARGET  = 3'd6;
    localparam logic [2:0] REG_SERVICE_RATE = 3'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [23:0] queue_size;
        logic [15:0] packet_size;
        logic [15:0] random_value;
        logic [31:0] time_now;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [15:0] probability_out;
        logic [31:0] queue_average_out;
        logic [31:0] early_drop_total;
        logic [31:0] forced_drop_total;
    } out_item_t;

    typedef struct packed {
        logic        byte_mode;
        logic [23:0] queue_limit;
        logic [15:0] queue_weight;
        logic [15:0] rate_weight;
        logic [15:0] delay_weight;
        logic [31:0] queue_target;
        logic [31:0] load_target;
        logic [31:0] service_rate;
    } cfg_t;

    // Rounded Q1.16 product; the operands never exceed 1.0, so p fits 33 bits.
    function automatic logic [16:0] qround(input logic [63:0] p);
        logic [33:0] s;
        s = 34'(p[32:0]) + 34'd32768;
        return s[32:16];
    endfunction

endpackage

/* design/ldaqm_front.sv */
// Front end of the AQM engine: accepts input transfers into a short queue
// that decouples the handshake from the back-end sequencer. Uses ldaqm_pkg.
module ldaqm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ldaqm_pkg::in_item_t in_data,
    output logic                q_valid,
    input  logic                q_pop,
    output ldaqm_pkg::in_item_t q_data
);
    import ldaqm_pkg::*;

    in_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign in_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign q_valid  = count_reg != '0;
    assign q_data   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* design/ldaqm_back.sv */
// Back end of the AQM engine: a sequencer with one shared multiplier, a
// square-and-multiply power loop and a bit-serial divider. Uses ldaqm_pkg.
module ldaqm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ldaqm_pkg::cfg_t      cfg,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  ldaqm_pkg::in_item_t  q_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ldaqm_pkg::out_item_t out_data
);
    import ldaqm_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_LD_A   = 5'd1;
    localparam logic [4:0] ST_LD_B   = 5'd2;
    localparam logic [4:0] ST_LD_C   = 5'd3;
    localparam logic [4:0] ST_SLOT   = 5'd4;
    localparam logic [4:0] ST_PW_R   = 5'd5;
    localparam logic [4:0] ST_PW_B   = 5'd6;
    localparam logic [4:0] ST_PW_W   = 5'd7;
    localparam logic [4:0] ST_QA_A   = 5'd8;
    localparam logic [4:0] ST_QA_B   = 5'd9;
    localparam logic [4:0] ST_QA_C   = 5'd10;
    localparam logic [4:0] ST_RT_SET = 5'd11;
    localparam logic [4:0] ST_RT_DIV = 5'd12;
    localparam logic [4:0] ST_RT_END = 5'd13;
    localparam logic [4:0] ST_PR_A   = 5'd14;
    localparam logic [4:0] ST_PR_B   = 5'd15;
    localparam logic [4:0] ST_PR_C   = 5'd16;
    localparam logic [4:0] ST_FIN    = 5'd17;

    localparam logic [39:0] SLOT_MAX = 40'((64'd1 << IDLE_SLOT_BITS) - 64'd1);

    logic [4:0]        state_reg, state_next;
    logic [4:0]        ret_reg, ret_next;
    in_item_t          cur_reg, cur_next;
    logic [31:0]       qavg_reg, qavg_next;
    logic [31:0]       load_reg, load_next;
    logic [15:0]       arr_reg, arr_next;
    logic [15:0]       prob_reg, prob_next;
    logic              idle_reg, idle_next;
    logic [31:0]       idle_start_reg, idle_start_next;
    logic [31:0]       early_reg, early_next;
    logic [31:0]       forced_reg, forced_next;
    logic [63:0]       prod_reg;
    logic [48:0]       acc_reg, acc_next;
    logic [16:0]       pb_reg, pb_next;
    logic [16:0]       pr_reg, pr_next;
    logic [PEXP_W-1:0] pe_reg, pe_next;
    logic [31:0]       rem_reg, rem_next;
    logic [15:0]       quo_reg, quo_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [16:0]       qt_reg, qt_next;
    logic              tsel_reg, tsel_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic [31:0] mul_a, mul_b;
    logic        out_free;
    logic        forced;
    logic [49:0] sum;
    logic [IDLE_SLOT_BITS-1:0] slots;
    logic [31:0] ratio_x, ratio_t;
    logic [32:0] rem2;
    logic        ge;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        cur_next        = cur_reg;
        qavg_next       = qavg_reg;
        load_next       = load_reg;
        arr_next        = arr_reg;
        prob_next       = prob_reg;
        idle_next       = idle_reg;
        idle_start_next = idle_start_reg;
        early_next      = early_reg;
        forced_next     = forced_reg;
        acc_next        = acc_reg;
        pb_next         = pb_reg;
        pr_next         = pr_reg;
        pe_next         = pe_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dcnt_next       = dcnt_reg;
        qt_next         = qt_reg;
        tsel_next       = tsel_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        q_pop           = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        forced          = 1'b0;
        sum             = 50'(acc_reg) + 50'(prod_reg[48:0]) + 50'd32768;
        slots           = '0;
        ratio_x         = tsel_reg ? load_reg : qavg_reg;
        ratio_t         = tsel_reg ? cfg.load_target : cfg.queue_target;
        rem2            = {rem_reg, 1'b0};
        ge              = rem2 >= {1'b0, ratio_t};

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && (q_data.opcode == OP_TICK || out_free))
                begin
                    q_pop    = 1'b1;
                    cur_next = q_data;
                    // A tick may start while a result still waits, so it leaves it alone.
                    if (q_data.opcode != OP_TICK)
                    begin
                        out_next.verdict           = VERDICT_ACCEPT;
                        out_next.probability_out   = prob_reg;
                        out_next.queue_average_out = qavg_reg;
                        out_next.early_drop_total  = early_reg;
                        out_next.forced_drop_total = forced_reg;
                    end
                    case (q_data.opcode)
                        OP_ARRIVAL:
                        begin
                            if (arr_reg != 16'hFFFF)
                            begin
                                arr_next = arr_reg + 16'd1;
                            end
                            if (cfg.byte_mode)
                            begin
                                forced = (25'(q_data.queue_size) + 25'(q_data.packet_size))
                                         > 25'(cfg.queue_limit);
                            end
                            else
                            begin
                                forced = q_data.queue_size >= cfg.queue_limit;
                            end
                            if (forced)
                            begin
                                forced_next = forced_reg + 32'd1;
                                out_next.verdict = VERDICT_FORCED;
                                out_next.forced_drop_total = forced_reg + 32'd1;
                            end
                            else if (q_data.random_value <= prob_reg)
                            begin
                                early_next = early_reg + 32'd1;
                                out_next.verdict = VERDICT_EARLY;
                                out_next.early_drop_total = early_reg + 32'd1;
                            end
                            out_valid_next = 1'b1;
                        end
                        OP_TICK:
                        begin
                            state_next = ST_LD_A;
                        end
                        OP_DEQ_EMPTY:
                        begin
                            idle_next       = 1'b1;
                            idle_start_next = q_data.time_now;
                            out_valid_next  = 1'b1;
                        end
                        default:
                        begin
                            idle_next      = 1'b0;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_LD_A:
            begin
                mul_a      = 32'(ONE_Q16 - 17'(cfg.rate_weight));
                mul_b      = load_reg;
                state_next = ST_LD_B;
            end
            ST_LD_B:
            begin
                acc_next   = prod_reg[48:0];
                mul_a      = 32'(cfg.rate_weight);
                mul_b      = {8'd0, arr_reg, 8'd0};
                state_next = ST_LD_C;
            end
            ST_LD_C:
            begin
                load_next  = (sum[49:48] != 2'd0) ? 32'hFFFF_FFFF : sum[47:16];
                arr_next   = '0;
                mul_a      = cur_reg.time_now - idle_start_reg;
                mul_b      = cfg.service_rate;
                state_next = ST_SLOT;
            end
            ST_SLOT:
            begin
                if (idle_reg)
                begin
                    slots = (prod_reg[63:24] > SLOT_MAX) ? IDLE_SLOT_BITS'(SLOT_MAX)
                                                         : IDLE_SLOT_BITS'(prod_reg[63:24]);
                end
                idle_next  = 1'b0;
                pe_next    = PEXP_W'(slots) + PEXP_W'(1);
                pb_next    = ONE_Q16 - 17'(cfg.queue_weight);
                pr_next    = ONE_Q16;
                ret_next   = ST_QA_A;
                state_next = ST_PW_R;
            end
            ST_PW_R:
            begin
                mul_a      = 32'(pr_reg);
                mul_b      = 32'(pb_reg);
                state_next = ST_PW_B;
            end
            ST_PW_B:
            begin
                if (pe_reg[0])
                begin
                    pr_next = qround(prod_reg);
                end
                mul_a      = 32'(pb_reg);
                mul_b      = 32'(pb_reg);
                state_next = ST_PW_W;
            end
            ST_PW_W:
            begin
                pb_next = qround(prod_reg);
                pe_next = pe_reg >> 1;
                if ((pe_reg >> 1) == '0)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    state_next = ST_PW_R;
                end
            end
            ST_QA_A:
            begin
                mul_a      = qavg_reg;
                mul_b      = 32'(pr_reg);
                state_next = ST_QA_B;
            end
            ST_QA_B:
            begin
                acc_next   = prod_reg[48:0];
                mul_a      = 32'(cfg.queue_weight);
                mul_b      = {cur_reg.queue_size, 8'd0};
                state_next = ST_QA_C;
            end
            ST_QA_C:
            begin
                qavg_next  = (sum[49:48] != 2'd0) ? 32'hFFFF_FFFF : sum[47:16];
                tsel_next  = 1'b0;
                state_next = ST_RT_SET;
            end
            ST_RT_SET:
            begin
                // A zero target, or an average or load at or above it, gives a full term.
                if (ratio_t == '0 || ratio_x >= ratio_t)
                begin
                    pr_next    = ONE_Q16;
                    state_next = ST_RT_END;
                end
                else
                begin
                    rem_next   = ratio_x;
                    quo_next   = '0;
                    dcnt_next  = '0;
                    state_next = ST_RT_DIV;
                end
            end
            ST_RT_DIV:
            begin
                rem_next  = ge ? 32'(rem2 - {1'b0, ratio_t}) : rem2[31:0];
                quo_next  = {quo_reg[14:0], ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    pb_next    = {1'b0, quo_reg[14:0], ge};
                    pr_next    = ONE_Q16;
                    pe_next    = PEXP_W'(LOAD_EXPONENT);
                    ret_next   = ST_RT_END;
                    state_next = ST_PW_R;
                end
            end
            ST_RT_END:
            begin
                if (!tsel_reg)
                begin
                    qt_next    = pr_reg;
                    tsel_next  = 1'b1;
                    state_next = ST_RT_SET;
                end
                else
                begin
                    state_next = ST_PR_A;
                end
            end
            ST_PR_A:
            begin
                mul_a      = 32'(cfg.delay_weight);
                mul_b      = 32'(qt_reg);
                state_next = ST_PR_B;
            end
            ST_PR_B:
            begin
                acc_next   = prod_reg[48:0];
                mul_a      = 32'(ONE_Q16 - 17'(cfg.delay_weight));
                mul_b      = 32'(pr_reg);
                state_next = ST_PR_C;
            end
            ST_PR_C:
            begin
                prob_next  = (sum[49:32] != '0) ? 16'hFFFF : sum[31:16];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_next.verdict           = VERDICT_ACCEPT;
                    out_next.probability_out   = prob_reg;
                    out_next.queue_average_out = qavg_reg;
                    out_next.early_drop_total  = early_reg;
                    out_next.forced_drop_total = forced_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            qavg_reg       <= '0;
            load_reg       <= '0;
            arr_reg        <= '0;
            prob_reg       <= '0;
            idle_reg       <= 1'b1;
            idle_start_reg <= '0;
            early_reg      <= '0;
            forced_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            qavg_reg       <= qavg_next;
            load_reg       <= load_next;
            arr_reg        <= arr_next;
            prob_reg       <= prob_next;
            idle_reg       <= idle_next;
            idle_start_reg <= idle_start_next;
            early_reg      <= early_next;
            forced_reg     <= forced_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        ret_reg  <= ret_next;
        cur_reg  <= cur_next;
        acc_reg  <= acc_next;
        pb_reg   <= pb_next;
        pr_reg   <= pr_next;
        pe_reg   <= pe_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dcnt_reg <= dcnt_next;
        qt_reg   <= qt_next;
        tsel_reg <= tsel_next;
        out_reg  <= out_next;
    end

endmodule

/* design/load_delay_aqm_drop_engine.sv */
// Channel   | Signals                          | Transfer when
// ----------+----------------------------------+------------------------------
// input     | in_valid, in_ready, in_data      | in_valid && in_ready
// output    | out_valid, out_ready, out_data   | out_valid && out_ready
// config    | psel, penable, pwrite, paddr ... | psel && penable && pwrite
//
// Arrivals and dequeue events are answered from the idle state once the output is free.
// A tick runs through the shared multiplier, the power loop and the 16-step divider.
// Reset is asynchronous, active low, and the block is ready straight after it.
// The two-entry input queue keeps accepting, until full, while a result waits for out_ready.
//
// Top level of the load/delay AQM drop engine: configuration registers and the
// front and back ends. Depends on ldaqm_pkg, ldaqm_front and ldaqm_back.
module load_delay_aqm_drop_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ldaqm_pkg::in_item_t          in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ldaqm_pkg::out_item_t         out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ldaqm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import ldaqm_pkg::*;

    cfg_t     cfg_reg;
    logic     q_valid, q_pop;
    in_item_t q_data;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.byte_mode    <= 1'b0;
            cfg_reg.queue_limit  <= 24'd25;
            cfg_reg.queue_weight <= 16'd131;
            cfg_reg.rate_weight  <= 16'd65404;
            cfg_reg.delay_weight <= 16'd49152;
            cfg_reg.queue_target <= 32'd384000;
            cfg_reg.load_target  <= 32'd182;
            cfg_reg.service_rate <= 32'd6291;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_BYTE_MODE:    cfg_reg.byte_mode    <= pwdata[0];
                REG_QUEUE_LIMIT:  cfg_reg.queue_limit  <= pwdata[23:0];
                REG_QUEUE_WEIGHT: cfg_reg.queue_weight <= pwdata[15:0];
                REG_RATE_WEIGHT:  cfg_reg.rate_weight  <= pwdata[15:0];
                REG_DELAY_WEIGHT: cfg_reg.delay_weight <= pwdata[15:0];
                REG_QUEUE_TARGET: cfg_reg.queue_target <= pwdata;
                REG_LOAD_TARGET:  cfg_reg.load_target  <= pwdata;
                REG_SERVICE_RATE: cfg_reg.service_rate <= pwdata;
                default:          cfg_reg.byte_mode    <= cfg_reg.byte_mode;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_BYTE_MODE:    prdata = {31'd0, cfg_reg.byte_mode};
            REG_QUEUE_LIMIT:  prdata = {8'd0, cfg_reg.queue_limit};
            REG_QUEUE_WEIGHT: prdata = {16'd0, cfg_reg.queue_weight};
            REG_RATE_WEIGHT:  prdata = {16'd0, cfg_reg.rate_weight};
            REG_DELAY_WEIGHT: prdata = {16'd0, cfg_reg.delay_weight};
            REG_QUEUE_TARGET: prdata = cfg_reg.queue_target;
            REG_LOAD_TARGET:  prdata = cfg_reg.load_target;
            REG_SERVICE_RATE: prdata = cfg_reg.service_rate;
            default:          prdata = '0;
        endcase
    end

    ldaqm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    ldaqm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* design/ldaqm_checker.sv */
// Port-level checker for the load/delay AQM drop engine, bound to the top
// level. Depends on ldaqm_pkg and load_delay_aqm_drop_engine.
module ldaqm_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input ldaqm_pkg::out_item_t out_data
);
    import ldaqm_pkg::*;

    // A result waiting for the sink must hold still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or vanished while stalled");

    // Only the three defined verdicts may appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.verdict == VERDICT_ACCEPT ||
                       out_data.verdict == VERDICT_EARLY ||
                       out_data.verdict == VERDICT_FORCED))
        else $error("undefined verdict code");

    // No result can be pending straight after reset is released.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result presented without any input transfer");

endmodule

bind load_delay_aqm_drop_engine ldaqm_checker u_chk (.*);
